// ===== rtl/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// Sampled position interpolator package
// Shared constants, codes and pipeline types.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int FRAC_BITS   = 16;
	localparam int COUNT_W     = 11;
	localparam int RATE_W      = 10;
	localparam int DATA_W      = 32;
	localparam int PADDR_W     = 4;

	// Integer phase magnitude is split into nibbles for the modulo chain.
	localparam int STEP_BITS   = 4;
	localparam int MOD_STAGES  = 7;
	localparam int DVD_W       = STEP_BITS * MOD_STAGES;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_RATE  = 2'd1;
	localparam logic [1:0] REG_START = 2'd2;
	localparam logic [1:0] REG_LOOP  = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_DATA = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_LAST    = 2'd3;

	typedef struct packed {
		logic                      op;
		logic [IDX_W-1:0]          widx;
		logic signed [DATA_W-1:0]  wx;
		logic signed [DATA_W-1:0]  wy;
		logic signed [DATA_W-1:0]  wz;
		logic [1:0]                stat;
		logic                      neg;
		logic [FRAC_BITS-1:0]      frac;
		logic [COUNT_W-1:0]        nidx;
	} pipe_t;

endpackage

// ===== rtl/spi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module spi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/spi_mod_step.sv =====
// ----------------------------------------------------------------------------
// Modulo step
// One registered stage of a restoring remainder, a nibble of dividend a stage.
// ----------------------------------------------------------------------------
module spi_mod_step (
	input  logic                          clk,
	input  logic                          en,
	input  logic [spi_pkg::COUNT_W-1:0]   divisor,
	input  logic [spi_pkg::COUNT_W-1:0]   rem_in,
	input  logic [spi_pkg::DVD_W-1:0]     dvd_in,
	output logic [spi_pkg::COUNT_W-1:0]   rem_s1,
	output logic [spi_pkg::DVD_W-1:0]     dvd_s1
);
	import spi_pkg::*;

	logic [COUNT_W-1:0] rem_nx;
	logic [DVD_W-1:0]   dvd_nx;

	always_comb begin
		logic [COUNT_W:0] r;
		rem_nx = rem_in;
		dvd_nx = dvd_in;
		for (int i = 0; i < STEP_BITS; i++) begin
			r = {rem_nx, dvd_nx[DVD_W-1]};
			dvd_nx = {dvd_nx[DVD_W-2:0], 1'b0};
			if (r >= {1'b0, divisor}) begin
				r = r - {1'b0, divisor};
			end
			rem_nx = r[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= rem_nx;
			dvd_s1 <= dvd_nx;
		end
	end

endmodule

// ===== rtl/spi_lerp.sv =====
// ----------------------------------------------------------------------------
// Linear interpolation
// Three stages: difference, scale by the fraction, add back the base sample.
// ----------------------------------------------------------------------------
module spi_lerp (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [spi_pkg::DATA_W-1:0]   a,
	input  logic signed [spi_pkg::DATA_W-1:0]   b,
	input  logic [spi_pkg::FRAC_BITS-1:0]       frac,
	output logic signed [spi_pkg::DATA_W-1:0]   res_s3
);
	import spi_pkg::*;

	localparam int PROD_W = DATA_W + 1 + FRAC_BITS + 1;

	logic signed [DATA_W:0]     d_s1;
	logic signed [DATA_W-1:0]   a_s1, a_s2;
	logic [FRAC_BITS-1:0]       frac_s1;
	logic signed [PROD_W-1:0]   p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= $signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a});
			a_s1    <= a;
			frac_s1 <= frac;
			p_s2    <= d_s1 * $signed({1'b0, frac_s1});
			a_s2    <= a_s1;
			// Only the low word of the sum survives, so the floor shift needs no sign bits.
			res_s3  <= a_s2 + $signed(p_s2[FRAC_BITS +: DATA_W]);
		end
	end

endmodule

// ===== rtl/sampled_position_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// Sampled position interpolator
// Table of 3D samples at a fixed rate, evaluated by linear interpolation.
// ----------------------------------------------------------------------------
// The core takes one beat per clock while the skid register is empty and
// returns one result beat per evaluate beat, in order; write beats give no
// result. A beat passes through the seven-stage remainder chain that wraps
// the phase in loop mode, the sample table read and the three-stage
// interpolation multiplier. The whole pipeline halts together only when
// both the output register and its skid register are full. Table writes
// take effect in the pipeline order, so an evaluate beat always sees every
// write beat accepted before it. Entries never written read as garbage.
module sampled_position_interpolator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [spi_pkg::PADDR_W-1:0]          paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic                                 opcode,
	input  logic [spi_pkg::IDX_W-1:0]            write_index,
	input  logic signed [spi_pkg::DATA_W-1:0]    in_x,
	input  logic signed [spi_pkg::DATA_W-1:0]    in_y,
	input  logic signed [spi_pkg::DATA_W-1:0]    in_z,
	input  logic signed [spi_pkg::DATA_W-1:0]    query_time,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic [1:0]                           status,
	output logic signed [spi_pkg::DATA_W-1:0]    out_x,
	output logic signed [spi_pkg::DATA_W-1:0]    out_y,
	output logic signed [spi_pkg::DATA_W-1:0]    out_z
);
	import spi_pkg::*;

	localparam int PHASE_W = DATA_W + 1 + RATE_W + 1;
	localparam int INT_W   = PHASE_W - FRAC_BITS;

	// Configuration registers.
	logic [COUNT_W-1:0]       count_q;
	logic [RATE_W-1:0]        rate_q;
	logic signed [DATA_W-1:0] start_q;
	logic                     loop_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rate_q  <= RATE_W'(1);
			start_q <= '0;
			loop_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_COUNT: count_q <= pwdata[COUNT_W-1:0];
				REG_RATE:  rate_q  <= pwdata[RATE_W-1:0];
				REG_START: start_q <= pwdata;
				REG_LOOP:  loop_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COUNT: prdata = {{(32-COUNT_W){1'b0}}, count_q};
			REG_RATE:  prdata = {{(32-RATE_W){1'b0}}, rate_q};
			REG_START: prdata = start_q;
			REG_LOOP:  prdata = {31'b0, loop_q};
			default:   prdata = '0;
		endcase
	end

	// Pipeline advance: everything moves unless the skid register is holding a beat.
	logic adv;
	logic skid_valid_q;

	assign adv       = !skid_valid_q;
	assign req_ready = adv;

	// Stage 1: time difference.
	logic                      v_s1;
	pipe_t                     c_s1;
	logic signed [DATA_W:0]    diff_s1;
	// Stage 2: phase.
	logic                      v_s2;
	pipe_t                     c_s2;
	logic signed [PHASE_W-1:0] phase_s2;
	// Stage 3: status and remainder operand.
	logic                      v_s3;
	pipe_t                     c_s3;
	logic [DVD_W-1:0]          u_s3;
	// Remainder chain.
	logic                      mv_s [MOD_STAGES];
	pipe_t                     mc_s [MOD_STAGES];
	logic [COUNT_W-1:0]        rem_s [MOD_STAGES];
	logic [DVD_W-1:0]          dvd_s [MOD_STAGES];
	// Stage 11 onwards: table data and interpolation.
	logic                      v_s11, v_s12, v_s13, v_s14;
	logic                      op_s11, op_s12, op_s13, op_s14;
	logic [1:0]                st_s11, st_s12, st_s13, st_s14;
	logic [FRAC_BITS-1:0]      frac_s11;

	pipe_t                     c_in;
	logic signed [INT_W-1:0]   ipart;
	logic [1:0]                st3;
	pipe_t                     c3_nx;

	// The range check needs the sign of the difference of the same beat, so it
	// travels alongside the phase into stage 2.
	logic diff_neg_s2;

	always_comb begin
		c_in       = '0;
		c_in.op    = opcode;
		c_in.widx  = write_index;
		c_in.wx    = in_x;
		c_in.wy    = in_y;
		c_in.wz    = in_z;
	end

	assign ipart = phase_s2[PHASE_W-1:FRAC_BITS];

	always_comb begin
		if (count_q == '0) begin
			st3 = ST_NO_DATA;
		end else if (!loop_q && (diff_neg_s2 ||
				phase_s2 > $signed({{(PHASE_W-COUNT_W-FRAC_BITS){1'b0}}, count_q,
					{FRAC_BITS{1'b0}}}))) begin
			st3 = ST_RANGE;
		end else begin
			st3 = ST_OK;
		end
	end

	always_comb begin
		c3_nx      = c_s2;
		c3_nx.stat = st3;
		c3_nx.neg  = ipart[INT_W-1];
		c3_nx.frac = phase_s2[FRAC_BITS-1:0];
		c3_nx.nidx = ipart[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (adv) begin
			v_s1  <= req_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s11 <= mv_s[MOD_STAGES-1];
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1        <= c_in;
			diff_s1     <= $signed({query_time[DATA_W-1], query_time})
				- $signed({start_q[DATA_W-1], start_q});
			c_s2        <= c_s1;
			diff_neg_s2 <= diff_s1[DATA_W];
			phase_s2    <= diff_s1 * $signed({1'b0, rate_q});
			c_s3        <= c3_nx;
			u_s3        <= ipart[INT_W-1] ? DVD_W'(~ipart) : DVD_W'(ipart);
		end
	end

	genvar k;
	generate
		for (k = 0; k < MOD_STAGES; k++) begin : g_mod
			if (k == 0) begin : g_first
				spi_mod_step u_step (
					.clk     (clk),
					.en      (adv),
					.divisor (count_q),
					.rem_in  ({COUNT_W{1'b0}}),
					.dvd_in  (u_s3),
					.rem_s1  (rem_s[k]),
					.dvd_s1  (dvd_s[k])
				);
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						mv_s[k] <= 1'b0;
					end else if (adv) begin
						mv_s[k] <= v_s3;
					end
				end
				always_ff @(posedge clk) begin
					if (adv) begin
						mc_s[k] <= c_s3;
					end
				end
			end else begin : g_next
				spi_mod_step u_step (
					.clk     (clk),
					.en      (adv),
					.divisor (count_q),
					.rem_in  (rem_s[k-1]),
					.dvd_in  (dvd_s[k-1]),
					.rem_s1  (rem_s[k]),
					.dvd_s1  (dvd_s[k])
				);
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						mv_s[k] <= 1'b0;
					end else if (adv) begin
						mv_s[k] <= mv_s[k-1];
					end
				end
				always_ff @(posedge clk) begin
					if (adv) begin
						mc_s[k] <= mc_s[k-1];
					end
				end
			end
		end
	endgenerate

	// Sample index and last-interval check at the end of the remainder chain.
	pipe_t              cm;
	logic [COUNT_W-1:0] rm;
	logic [COUNT_W-1:0] idx;
	logic [COUNT_W:0]   idx_next;
	logic [1:0]         st10;

	assign cm = mc_s[MOD_STAGES-1];
	assign rm = rem_s[MOD_STAGES-1];

	always_comb begin
		if (loop_q) begin
			// Negative phase: floor remainder is count - 1 - (remainder of magnitude minus one).
			idx = cm.neg ? count_q - COUNT_W'(1) - rm : rm;
		end else begin
			idx = cm.nidx;
		end
		idx_next = {1'b0, idx} + (COUNT_W+1)'(1);
		if (cm.stat == ST_OK && (idx >= count_q - COUNT_W'(1) ||
				idx_next >= (COUNT_W+1)'(MAX_SAMPLES))) begin
			st10 = ST_LAST;
		end else begin
			st10 = cm.stat;
		end
	end

	logic                    ram_we;
	logic [3*DATA_W-1:0]     rd_a, rd_b;

	assign ram_we = adv && mv_s[MOD_STAGES-1] && cm.op == OP_WRITE;

	spi_ram #(
		.WIDTH (3*DATA_W),
		.DEPTH (MAX_SAMPLES)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (cm.widx),
		.wdata   ({cm.wx, cm.wy, cm.wz}),
		.re      (adv),
		.raddr_a (idx[IDX_W-1:0]),
		.raddr_b (idx_next[IDX_W-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s11   <= cm.op;
			st_s11   <= st10;
			frac_s11 <= cm.frac;
			op_s12   <= op_s11;
			st_s12   <= st_s11;
			op_s13   <= op_s12;
			st_s13   <= st_s12;
			op_s14   <= op_s13;
			st_s14   <= st_s13;
		end
	end

	logic signed [DATA_W-1:0] lx_s14, ly_s14, lz_s14;

	spi_lerp u_lerp_x (
		.clk    (clk),
		.en     (adv),
		.a      ($signed(rd_a[3*DATA_W-1 -: DATA_W])),
		.b      ($signed(rd_b[3*DATA_W-1 -: DATA_W])),
		.frac   (frac_s11),
		.res_s3 (lx_s14)
	);

	spi_lerp u_lerp_y (
		.clk    (clk),
		.en     (adv),
		.a      ($signed(rd_a[2*DATA_W-1 -: DATA_W])),
		.b      ($signed(rd_b[2*DATA_W-1 -: DATA_W])),
		.frac   (frac_s11),
		.res_s3 (ly_s14)
	);

	spi_lerp u_lerp_z (
		.clk    (clk),
		.en     (adv),
		.a      ($signed(rd_a[DATA_W-1:0])),
		.b      ($signed(rd_b[DATA_W-1:0])),
		.frac   (frac_s11),
		.res_s3 (lz_s14)
	);

	// Output register with a one-beat skid behind it.
	logic                     push;
	logic                     out_valid_q;
	logic [1:0]               out_st_q, skid_st_q, new_st;
	logic signed [DATA_W-1:0] out_x_q, out_y_q, out_z_q;
	logic signed [DATA_W-1:0] skid_x_q, skid_y_q, skid_z_q;
	logic signed [DATA_W-1:0] new_x, new_y, new_z;
	logic                     ok14;

	assign push   = adv && v_s14 && op_s14 == OP_EVAL;
	assign ok14   = st_s14 == ST_OK;
	assign new_st = st_s14;
	assign new_x  = ok14 ? lx_s14 : '0;
	assign new_y  = ok14 ? ly_s14 : '0;
	assign new_z  = ok14 ? lz_s14 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || rsp_ready) begin
			if (skid_valid_q) begin
				out_st_q <= skid_st_q;
				out_x_q  <= skid_x_q;
				out_y_q  <= skid_y_q;
				out_z_q  <= skid_z_q;
			end else begin
				out_st_q <= new_st;
				out_x_q  <= new_x;
				out_y_q  <= new_y;
				out_z_q  <= new_z;
			end
		end else if (push) begin
			skid_st_q <= new_st;
			skid_x_q  <= new_x;
			skid_y_q  <= new_y;
			skid_z_q  <= new_z;
		end
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_st_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a beat while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !rsp_ready))
		else $error("skid register filled without an output stall");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s14) && $stable(v_s1))
		else $error("pipeline moved during a stall");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("failed result carries a non-zero position");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Sampled position interpolator testbench
// Checks the core against its own position predictor, starting with a table
// of directed beats and then moving through random phases. Each phase uses
// its own register setting and one of four idling patterns.
// ----------------------------------------------------------------------------
module testbench;

	import spi_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 24;

	typedef struct packed {
		logic [1:0]         st;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} position_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_EVAL, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [9:0]         idx;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] t;
		logic [1:0]         reg_sel;
		logic               typed;
		position_t          want;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic req_valid, req_ready;
	logic opcode;
	logic [IDX_W-1:0] write_index;
	logic signed [31:0] in_x, in_y, in_z, query_time;
	logic rsp_valid, rsp_ready;
	logic [1:0] status;
	logic signed [31:0] out_x, out_y, out_z;

	sampled_position_interpolator_core dut (.*);

	// Predictor state.
	logic signed [31:0] table_x [MAX_SAMPLES];
	logic signed [31:0] table_y [MAX_SAMPLES];
	logic signed [31:0] table_z [MAX_SAMPLES];
	bit                 filled [MAX_SAMPLES];
	logic [10:0]        num_samples;
	logic [9:0]         rate_hz;
	logic signed [31:0] t_start;
	logic               wrap_on;

	position_t expected_positions[$];
	int mismatches;
	int cycle_count;
	int send_idle_pct;
	int stall_pct;
	row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= stall_pct);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		position_t w;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_positions.size() == 0) begin
				report_mismatch("unexpected beat", {30'd0, status}, 32'd0);
			end else begin
				w = expected_positions.pop_front();
				if (status !== w.st) report_mismatch("status", {30'd0, status}, {30'd0, w.st});
				if (out_x !== w.x) report_mismatch("out_x", out_x, w.x);
				if (out_y !== w.y) report_mismatch("out_y", out_y, w.y);
				if (out_z !== w.z) report_mismatch("out_z", out_z, w.z);
			end
		end
	end

	function automatic logic signed [31:0] blend(input logic signed [31:0] a,
			input logic signed [31:0] b, input longint f);
		longint va, d;
		va = longint'(a);
		d = longint'(b) - va;
		return 32'(va + ((d * f) >>> FRAC_BITS));
	endfunction

	// Works out the position at time t; need names a table entry that the
	// interpolation would read but that has not been written yet, else -1.
	function automatic void predict_position(input logic signed [31:0] t,
			output position_t r, output int need);
		longint diff, ph, per, fr, idx;
		r = '0;
		need = -1;
		if (num_samples == 0) begin
			r.st = ST_NO_DATA;
			return;
		end
		diff = longint'(t) - longint'(t_start);
		ph = diff * longint'(rate_hz);
		per = longint'(num_samples) <<< FRAC_BITS;
		if (wrap_on) begin
			ph = ph % per;
			if (ph < 0) ph += per;
		end else if (diff < 0 || ph > per) begin
			r.st = ST_RANGE;
			return;
		end
		idx = ph >>> FRAC_BITS;
		fr = ph & 64'hFFFF;
		if (idx >= longint'(num_samples) - 1 || idx + 1 >= MAX_SAMPLES) begin
			r.st = ST_LAST;
			return;
		end
		if (!filled[idx]) need = int'(idx);
		else if (!filled[idx+1]) need = int'(idx + 1);
		r.st = ST_OK;
		r.x = blend(table_x[idx], table_x[idx+1], fr);
		r.y = blend(table_y[idx], table_y[idx+1], fr);
		r.z = blend(table_z[idx], table_z[idx+1], fr);
	endfunction

	task automatic send_beat(input logic op, input logic [9:0] idx,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic signed [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		write_index <= idx;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		query_time <= t;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic write_sample(input logic [9:0] idx, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		table_x[idx] = x;
		table_y[idx] = y;
		table_z[idx] = z;
		filled[idx] = 1'b1;
		send_beat(OP_WRITE, idx, x, y, z, $urandom);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
		// Write beats give no result, so let the pipeline empty as well.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (sel)
			REG_COUNT: num_samples = value[10:0];
			REG_RATE:  rate_hz = value[9:0];
			REG_START: t_start = value;
			REG_LOOP:  wrap_on = value[0];
			default: ;
		endcase
	endtask

	task automatic evaluate(input logic signed [31:0] t);
		position_t r;
		int need;
		predict_position(t, r, need);
		while (need >= 0) begin
			write_sample(need[9:0], $urandom, $urandom, $urandom);
			predict_position(t, r, need);
		end
		expected_positions.push_back(r);
		send_beat(OP_EVAL, 10'($urandom), $urandom, $urandom, $urandom, t);
	endtask

	function automatic row_t mk_write(input logic [9:0] idx, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		row_t r;
		r = '{kind: ROW_WRITE, idx: idx, x: x, y: y, z: z, t: '0, reg_sel: REG_COUNT,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic row_t mk_eval(input logic [31:0] t, input logic typed,
			input logic [1:0] st, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		row_t r;
		r = '{kind: ROW_EVAL, idx: '0, x: '0, y: '0, z: '0, t: t, reg_sel: REG_COUNT,
			typed: typed, want: '{st, x, y, z}};
		return r;
	endfunction

	function automatic row_t mk_reg(input logic [1:0] sel, input logic [31:0] value);
		row_t r;
		r = '{kind: ROW_REG, idx: '0, x: '0, y: '0, z: '0, t: value, reg_sel: sel,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	initial begin
		position_t r;
		int need;
		logic [10:0] n;
		logic [9:0] rt;
		longint p;
		logic signed [31:0] t;

		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req_valid = 1'b0; opcode = OP_WRITE; write_index = '0;
		in_x = '0; in_y = '0; in_z = '0; query_time = '0;
		rsp_ready = 1'b0;
		mismatches = 0; cycle_count = 0;
		send_idle_pct = 0; stall_pct = 0;
		num_samples = '0; rate_hz = 10'd1; t_start = '0; wrap_on = 1'b0;
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			filled[i] = 1'b0;
			table_x[i] = '0; table_y[i] = '0; table_z[i] = '0;
		end

		// Empty table first, then a four-sample table with extreme values,
		// probed below the start, inside, at the end time, just past it and in loop mode.
		rows.push_back(mk_eval(32'h0000_0000, 1'b1, ST_NO_DATA, '0, '0, '0));
		rows.push_back(mk_eval(32'h7FFF_FFFF, 1'b1, ST_NO_DATA, '0, '0, '0));
		rows.push_back(mk_reg(REG_COUNT, 32'd4));
		rows.push_back(mk_reg(REG_RATE, 32'd1));
		rows.push_back(mk_reg(REG_START, 32'd0));
		rows.push_back(mk_reg(REG_LOOP, 32'd0));
		rows.push_back(mk_write(10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
		rows.push_back(mk_write(10'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
		rows.push_back(mk_write(10'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA));
		rows.push_back(mk_write(10'd3, 32'hAAAA_5555, 32'h0, 32'h7FFF_FFFF));
		rows.push_back(mk_write(10'd1023, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000));
		rows.push_back(mk_eval(32'hFFFF_FFFF, 1'b1, ST_RANGE, '0, '0, '0));
		rows.push_back(mk_eval(32'h8000_0000, 1'b1, ST_RANGE, '0, '0, '0));
		rows.push_back(mk_eval(32'h0, 1'b1, ST_OK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
		rows.push_back(mk_eval(32'h0000_8000, 1'b0, ST_OK, '0, '0, '0));
		rows.push_back(mk_eval(32'h0001_FFFF, 1'b0, ST_OK, '0, '0, '0));
		rows.push_back(mk_eval(32'h0004_0000, 1'b1, ST_LAST, '0, '0, '0));
		rows.push_back(mk_eval(32'h0004_0001, 1'b1, ST_RANGE, '0, '0, '0));
		rows.push_back(mk_eval(32'h7FFF_FFFF, 1'b1, ST_RANGE, '0, '0, '0));
		rows.push_back(mk_reg(REG_LOOP, 32'd1));
		rows.push_back(mk_eval(32'h8000_0000, 1'b0, ST_OK, '0, '0, '0));
		rows.push_back(mk_eval(32'hFFFF_8000, 1'b0, ST_OK, '0, '0, '0));
		rows.push_back(mk_eval(32'h7FFF_FFFF, 1'b0, ST_OK, '0, '0, '0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_WRITE: write_sample(rows[i].idx, rows[i].x, rows[i].y, rows[i].z);
				ROW_REG:   write_reg(rows[i].reg_sel, rows[i].t);
				ROW_EVAL: begin
					predict_position(rows[i].t, r, need);
					expected_positions.push_back(rows[i].typed ? rows[i].want : r);
					send_beat(OP_EVAL, 10'($urandom), $urandom, $urandom, $urandom,
						rows[i].t);
				end
				default: ;
			endcase
		end

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: n = 11'd2;
				1: n = 11'd16;
				2: n = 11'd1024;
				3: n = 11'd2047;
				4: n = 11'd1;
				5: n = 11'($urandom_range(2, 64));
				6: n = 11'd3;
				default: n = 11'($urandom_range(2, 300));
			endcase
			rt = (ph % 3 == 0) ? 10'd1023 : (ph == 4) ? 10'd0 : 10'($urandom_range(1, 1023));
			write_reg(REG_COUNT, {21'd0, n});
			write_reg(REG_RATE, {22'd0, rt});
			write_reg(REG_START, (ph == 2) ? 32'h8000_0000 :
				(ph == 6) ? 32'h7FFF_FFFF : $urandom);
			write_reg(REG_LOOP, {31'd0, ph[0]});
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 88; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 88; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			for (int k = 0; k < 105; k++) begin
				if ($urandom_range(9) < 3) begin
					write_sample(10'($urandom_range(0, 1023)), $urandom, $urandom, $urandom);
				end else begin
					if ($urandom_range(4) == 0) begin
						t = $urandom;
					end else begin
						p = longint'($urandom_range(0, int'(n) * 65536 + 65536));
						t = 32'(longint'(t_start) + ((rt != 0) ? p / longint'(rt) : p));
					end
					evaluate(t);
				end
			end
		end

		req_valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
